// ----- hw/rtl/lev_pkg.sv -----
// Shared types and constants of the Levenshtein automaton step unit.
// Holds the beat structs, request codes, register indexes and field widths.
// Used by every RTL file of the block; depends on nothing.
package lev_pkg;

    // Field widths fixed by the interface.
    localparam int CHAR_W    = 21;
    localparam int IDX_W     = 5;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_LEN    = 32;
    localparam int DEF_MAX_ERRORS = 3;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_RESTART = 2'd1;
    localparam logic [1:0] REQ_STEP    = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX  = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  pattern_index;
        logic [CHAR_W-1:0] char_value;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic accepting;
        logic rejecting;
    } t_out_beat;

endpackage

// ----- hw/rtl/lev_pat_mem.sv -----
// Pattern character memory with one write port and one registered read port.
// The read data is compared against the current step character.
// Depends on lev_pkg for the character width.
module lev_pat_mem #(
    parameter int DEPTH = lev_pkg::DEF_MAX_LEN,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lev_pkg::CHAR_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    input  logic [lev_pkg::CHAR_W-1:0] i_key,
    output logic                      o_match
);

    logic [lev_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [lev_pkg::CHAR_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    // The shared comparator sees one entry per cycle.
    assign o_match = (r_rdata == i_key);

endmodule

// ----- hw/rtl/lev_row_unit.sv -----
// Transition unit for one error row of the position set.
// Produces the contribution of that row to each destination row offset.
// Depends on lev_pkg only for its parameter defaults.
module lev_row_unit #(
    parameter int MAX_LEN    = lev_pkg::DEF_MAX_LEN,
    parameter int MAX_ERRORS = lev_pkg::DEF_MAX_ERRORS
) (
    input  logic [MAX_LEN:0]                    i_row,
    input  logic [MAX_LEN:0]                    i_match,
    input  logic [MAX_LEN:0]                    i_keep,
    input  logic [MAX_LEN:0]                    i_lt,
    input  logic [((MAX_ERRORS > 0) ? $clog2(MAX_ERRORS + 1) : 1)-1:0] i_row_idx,
    input  logic [((MAX_ERRORS > 0) ? $clog2(MAX_ERRORS + 1) : 1)-1:0] i_max_err,
    output logic [MAX_ERRORS:0][MAX_LEN:0]      o_contrib
);

    localparam int RW  = MAX_LEN + 1;
    localparam int NR  = MAX_ERRORS + 1;
    localparam int EVW = (MAX_ERRORS > 0) ? $clog2(MAX_ERRORS + 1) : 1;

    logic [RW-1:0]  blk;
    logic [RW-1:0]  rem;
    logic [RW-1:0]  fnd;
    logic [EVW-1:0] diff;

    assign diff = i_max_err - i_row_idx;

    // Match moves stay in the row; edit moves land one or more rows down.
    // A delete skips ahead to the first matching character within reach.
    always_comb begin
        blk = '0;
        rem = '0;
        fnd = '0;
        for (int k = 0; k < NR; k++) begin
            o_contrib[k] = '0;
        end
        o_contrib[0] = (i_row & i_match) << 1;
        if (i_row_idx < i_max_err) begin
            blk = i_row & ~i_match & i_keep;
            rem = blk;
            for (int i = 1; i < NR; i++) begin
                if (EVW'(i) <= diff) begin
                    if (i == 1) begin
                        o_contrib[i] = blk | ((blk & i_lt) << 1);
                    end
                    fnd = rem & (i_match >> i);
                    o_contrib[i] = o_contrib[i] | (fnd << (i + 1));
                    rem = rem & ~fnd;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/levenshtein_automaton_step_unit.sv -----
// Levenshtein automaton step unit: fuzzy word matcher on (offset, error) positions.
// A step beat is served by the one-entry-per-cycle sweep of the pattern memory and three
// row passes.
// Load, restart and unused beats take one report pass over the rows.
// One beat at a time; the next beat is taken the cycle after the result is registered.
// Reset: registers to length 0, max errors 1, prefix 0; set to offset 0 with 0 errors.
module levenshtein_automaton_step_unit #(
    parameter int MAX_LEN    = lev_pkg::DEF_MAX_LEN,
    parameter int MAX_ERRORS = lev_pkg::DEF_MAX_ERRORS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lev_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lev_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [lev_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lev_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int RW  = MAX_LEN + 1;
    localparam int NR  = MAX_ERRORS + 1;
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int EVW = (MAX_ERRORS > 0) ? $clog2(MAX_ERRORS + 1) : 1;
    localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW  = ((CW > EVW) ? CW : EVW) + 1;
    localparam logic [6:0] LEN_LIM = 7'(MAX_LEN);
    localparam logic [2:0] ERR_LIM = 3'(MAX_ERRORS);
    localparam logic [NR-1:0][RW-1:0] SET_ORIGIN = (NR*RW)'(1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SWEEP  = 3'd1;
    localparam logic [2:0] ST_TRANS  = 3'd2;
    localparam logic [2:0] ST_SUBS   = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [CW-1:0]                 r_cnt;
    logic [EVW-1:0]                r_row;
    logic [lev_pkg::CHAR_W-1:0]    r_char;
    logic [RW-1:0]                 r_mvec;
    logic [NR-1:0][RW-1:0]         r_set;
    logic [NR-1:0][RW-1:0]         r_nxt;
    logic [RW-1:0]                 r_cover;
    logic                          r_acc;
    logic                          r_any;
    lev_pkg::t_out_beat            r_out;
    logic                          r_out_valid;
    logic [lev_pkg::CFG_W-1:0]     r_pat_len;
    logic [1:0]                    r_max_err;
    logic [lev_pkg::CFG_W-1:0]     r_prefix;

    logic                          in_acc;
    logic                          last_row;
    logic                          slot_free;
    logic [CW-1:0]                 eff_len;
    logic [EVW-1:0]                eff_err;
    logic                          row_ok;
    logic [EVW-1:0]                me_left;
    logic [RW-1:0]                 lt_mask;
    logic [RW-1:0]                 le_mask;
    logic [RW-1:0]                 keep_mask;
    logic [RW-1:0]                 acc_mask;
    logic [RW-1:0]                 row_gate;
    logic [RW-1:0]                 cur_set;
    logic [RW-1:0]                 cur_nxt;
    logic [RW-1:0]                 new_row;
    logic [RW-1:0]                 cover_in;
    logic [RW-1:0]                 match_eff;
    logic [NR-1:0][RW-1:0]         contrib;
    logic                          mem_we;
    logic [AW-1:0]                 mem_raddr;
    logic                          mem_match;

    // Handshake and pass bookkeeping.
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign last_row    = (r_row == EVW'(MAX_ERRORS));
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Register values saturated to the built sizes.
    assign eff_len = ({1'b0, r_pat_len} > LEN_LIM) ? CW'(MAX_LEN) : CW'(r_pat_len);
    assign eff_err = ({1'b0, r_max_err} > ERR_LIM) ? EVW'(MAX_ERRORS) : EVW'(r_max_err);
    assign row_ok  = (r_row <= eff_err);
    assign me_left = eff_err - r_row;

    // Per-offset masks for the row under work.
    always_comb begin
        for (int o = 0; o < RW; o++) begin
            lt_mask[o]   = (CW'(o) < eff_len);
            le_mask[o]   = (CW'(o) <= eff_len);
            keep_mask[o] = (7'(o) >= {1'b0, r_prefix});
            acc_mask[o]  = ((SW'(o) + SW'(me_left)) >= SW'(eff_len));
        end
    end

    assign row_gate  = {RW{row_ok}};
    assign cur_set   = r_set[r_row] & le_mask & row_gate;
    assign cur_nxt   = r_nxt[r_row] & row_gate;
    assign new_row   = cur_nxt & ~r_cover;
    assign cover_in  = r_cover | cur_nxt;
    assign match_eff = r_mvec & lt_mask;

    // Pattern memory, swept one entry per cycle during a step.
    assign mem_we    = in_acc && (i_in_data.req_type == lev_pkg::REQ_LOAD) &&
                       ({2'b00, i_in_data.pattern_index} < LEN_LIM);
    assign mem_raddr = (r_cnt == CW'(MAX_LEN)) ? '0 : r_cnt[AW-1:0];

    lev_pat_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_pat_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_in_data.pattern_index)),
        .i_wdata (i_in_data.char_value),
        .i_raddr (mem_raddr),
        .i_key   (r_char),
        .o_match (mem_match)
    );

    // Shared transition unit, one source row per cycle.
    lev_row_unit #(
        .MAX_LEN    (MAX_LEN),
        .MAX_ERRORS (MAX_ERRORS)
    ) u_row_unit (
        .i_row     (cur_set),
        .i_match   (match_eff),
        .i_keep    (keep_mask),
        .i_lt      (lt_mask),
        .i_row_idx (r_row),
        .i_max_err (eff_err),
        .o_contrib (contrib)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.req_type == lev_pkg::REQ_STEP) ? ST_SWEEP : ST_REPORT;
                end
            end
            ST_SWEEP: begin
                if (r_cnt == CW'(MAX_LEN)) begin
                    n_state = ST_TRANS;
                end
            end
            ST_TRANS: begin
                if (last_row) begin
                    n_state = ST_SUBS;
                end
            end
            ST_SUBS: begin
                if (last_row) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (last_row) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers: state, counters, flags and the result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_row       <= '0;
            r_acc       <= 1'b0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_FINISH) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_row <= '0;
                    r_acc <= 1'b0;
                    r_any <= 1'b0;
                end
                ST_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_TRANS: begin
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end
                ST_SUBS: begin
                    r_row <= last_row ? '0 : r_row + 1'b1;
                    r_acc <= 1'b0;
                    r_any <= 1'b0;
                end
                ST_REPORT: begin
                    r_row <= r_row + 1'b1;
                    r_any <= r_any | (|cur_set);
                    r_acc <= r_acc | (|(cur_set & acc_mask));
                end
                ST_FINISH: begin
                    r_row <= '0;
                end
                default: begin
                    r_row <= '0;
                end
            endcase
        end
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FINISH) && slot_free) begin
            r_out.accepting <= r_acc;
            r_out.rejecting <= !r_any;
        end
    end

    // Step character and match vector from the memory sweep.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_char <= i_in_data.char_value;
            r_mvec <= '0;
        end
        if ((r_state == ST_SWEEP) && (r_cnt != '0)) begin
            r_mvec[r_cnt - 1'b1] <= mem_match;
        end
    end

    // Next-set accumulator and the running subsumption cover.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_nxt <= '0;
        end else if (r_state == ST_TRANS) begin
            for (int d = 0; d < NR; d++) begin
                if (EVW'(d) >= r_row) begin
                    r_nxt[d] <= r_nxt[d] | contrib[EVW'(d) - r_row];
                end
            end
        end
        if (r_state == ST_TRANS) begin
            r_cover <= '0;
        end else if (r_state == ST_SUBS) begin
            r_cover <= cover_in | (cover_in << 1) | (cover_in >> 1);
        end
    end

    // Position set: origin after reset or restart, rewritten row by row after a step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= SET_ORIGIN;
        end else if (in_acc && (i_in_data.req_type == lev_pkg::REQ_RESTART)) begin
            r_set <= SET_ORIGIN;
        end else if (r_state == ST_SUBS) begin
            r_set[r_row] <= new_row;
        end
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_max_err <= 2'd1;
            r_prefix  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lev_pkg::CFG_PAT_LEN: begin
                    r_pat_len <= i_cfg_data;
                end
                lev_pkg::CFG_MAX_ERR: begin
                    r_max_err <= i_cfg_data[1:0];
                end
                lev_pkg::CFG_PREFIX: begin
                    r_prefix <= i_cfg_data;
                end
                default: begin
                    r_prefix <= r_prefix;
                end
            endcase
        end
    end

endmodule
